[hdl/sps_pkg.sv]
// Shared types and constants for the servo pulse schedule table.
package sps_pkg;

	localparam logic [15:0] RESET_WIDTH = 16'd12000;
	localparam int          MASK_W      = 8;
	localparam logic [MASK_W-1:0] FULL_MASK = 8'hFF;

	typedef struct packed {
		logic [2:0]  channel;
		logic [15:0] pulse_width;
	} sps_in_t;

	typedef struct packed {
		logic [15:0]       event_time;
		logic [MASK_W-1:0] still_high_mask;
		logic              last_entry;
	} sps_out_t;

	// Control from the sequencer to the shared compare unit.
	typedef struct packed {
		logic        first;
		logic        have_prev;
		logic [15:0] prev;
	} sps_scan_ctrl_t;

endpackage

[hdl/sps_width_table.sv]
// Per-channel pulse width storage with one write port and one read port.
module sps_width_table
	import sps_pkg::*;
#(
	parameter int NUM_CHANNELS = 8,
	parameter int CW           = $clog2(NUM_CHANNELS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_idx,
	input  logic [15:0]   wr_data,
	input  logic [CW-1:0] rd_idx,
	output logic [15:0]   rd_data
);

	logic [15:0] width_q [NUM_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_q[i] <= RESET_WIDTH;
			end
		end else if (wr_en) begin
			width_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = width_q[rd_idx];

endmodule

[hdl/sps_scan_unit.sv]
// Shared compare unit: finds the smallest width above the previous entry time.
module sps_scan_unit
	import sps_pkg::*;
#(
	parameter int NUM_CHANNELS = 8,
	parameter int CW           = $clog2(NUM_CHANNELS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sps_scan_ctrl_t    ctrl,
	input  logic [CW-1:0]     chan,
	input  logic [15:0]       width,
	output logic              nxt_found,
	output logic [15:0]       nxt_best,
	output logic [MASK_W-1:0] nxt_ends
);

	logic              found_q;
	logic [15:0]       best_q;
	logic [MASK_W-1:0] ends_q;
	logic              cand;
	logic [MASK_W-1:0] chan_bit;

	// Channels above the mask field take part in ordering but flag no bit.
	always_comb begin
		chan_bit = '0;
		if ({{(32-CW){1'b0}}, chan} < MASK_W) begin
			chan_bit = MASK_W'(1) << chan;
		end
	end

	assign cand = !ctrl.have_prev || (width > ctrl.prev);

	always_comb begin
		nxt_found = found_q;
		nxt_best  = best_q;
		nxt_ends  = ends_q;
		if (ctrl.first) begin
			nxt_found = cand;
			nxt_best  = width;
			nxt_ends  = cand ? chan_bit : '0;
		end else if (cand && (!found_q || width < best_q)) begin
			nxt_found = 1'b1;
			nxt_best  = width;
			nxt_ends  = chan_bit;
		end else if (cand && width == best_q) begin
			nxt_ends = ends_q | chan_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (step) begin
			found_q <= nxt_found;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			best_q <= nxt_best;
			ends_q <= nxt_ends;
		end
	end

endmodule

[hdl/servo_pulse_schedule_table_unit.sv]
// Servo pulse schedule table: width store, scan sequencer and result register.
//
// Each accepted item writes one channel's width (a channel at or beyond
// NUM_CHANNELS writes nothing) and then emits NUM_CHANNELS schedule entries,
// each presented on result with strobe high for a single cycle.
// Entries list the distinct widths in ascending order with the bits of the
// channels ending there cleared from 0xFF; unused entries are zero, and
// last_entry marks the final one. The single compare unit looks at one stored
// width per cycle during each entry's scan, and busy is high while the
// entries are scanned; the final entry's strobe comes in the cycle after busy
// falls, and a new item may be started in that cycle. The receiver cannot
// stall: every strobed entry must be taken.
module servo_pulse_schedule_table_unit
	import sps_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sps_in_t  cmd,
	output logic     strobe,
	output sps_out_t result
);

	localparam int CW = $clog2(NUM_CHANNELS);
	localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CHANNELS - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     entry_q;
	logic              have_prev_q;
	logic [15:0]       prev_q;
	logic              strobe_q;
	sps_out_t          result_q;

	logic              accept;
	logic              wr_en;
	logic [15:0]       rd_width;
	logic              scanning;
	logic              scan_end;
	sps_scan_ctrl_t    scan_ctrl;
	logic              nxt_found;
	logic [15:0]       nxt_best;
	logic [MASK_W-1:0] nxt_ends;

	assign accept   = start && (state_q == ST_IDLE);
	assign wr_en    = accept && ({29'd0, cmd.channel} < NUM_CHANNELS);
	assign scanning = (state_q == ST_SCAN);
	assign scan_end = scanning && (idx_q == LAST_IDX);

	assign scan_ctrl.first     = (idx_q == '0);
	assign scan_ctrl.have_prev = have_prev_q;
	assign scan_ctrl.prev      = prev_q;

	sps_width_table #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CW(CW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_idx(CW'(cmd.channel)),
		.wr_data(cmd.pulse_width),
		.rd_idx(idx_q),
		.rd_data(rd_width)
	);

	sps_scan_unit #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CW(CW)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(scanning),
		.ctrl(scan_ctrl),
		.chan(idx_q),
		.width(rd_width),
		.nxt_found(nxt_found),
		.nxt_best(nxt_best),
		.nxt_ends(nxt_ends)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			entry_q     <= '0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= scan_end;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_SCAN;
						idx_q       <= '0;
						entry_q     <= '0;
						have_prev_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						idx_q   <= '0;
						entry_q <= entry_q + 1'b1;
						// advance the lower bound past the width just emitted
						if (nxt_found) begin
							have_prev_q <= 1'b1;
							prev_q      <= nxt_best;
						end
						if (entry_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_end) begin
			result_q.event_time      <= nxt_found ? nxt_best : 16'd0;
			result_q.still_high_mask <= nxt_found ? (FULL_MASK & ~nxt_ends) : '0;
			result_q.last_entry      <= (entry_q == LAST_IDX);
		end
	end

	assign busy   = scanning;
	assign strobe = strobe_q;
	assign result = result_q;

	a_strobe_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("entry strobed without a scan in progress");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not start a scan");

	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_entry |-> !busy)
		else $error("final entry emitted while still scanning");

	a_strobe_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("entries strobed in consecutive cycles");

endmodule

[verif/tb_servo_pulse_schedule_table_unit.sv]
`timescale 1ns / 1ps
// Testbench for the servo pulse schedule table unit: directed and random width writes.
module tb_servo_pulse_schedule_table_unit;
	import sps_pkg::*;

	localparam int CHANNELS     = 8;
	localparam int ITEM_CYCLES  = CHANNELS * CHANNELS + 1;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 130;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	logic     busy;
	sps_in_t  cmd    = '0;
	logic     strobe;
	sps_out_t result;

	logic [15:0] width_table [CHANNELS];
	sps_out_t    expected_entries [$];
	int          error_count = 0;
	int          idle_cycles = 0;
	bit          gaps_on     = 1'b1;

	servo_pulse_schedule_table_unit #(
		.NUM_CHANNELS(CHANNELS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Write the width, sort channels by width (ties by channel number),
	// merge equal widths and queue the full schedule.
	function automatic void predict_schedule(input sps_in_t item);
		logic [2:0]      order [CHANNELS];
		logic [2:0]      cur;
		logic [MASK_W-1:0] mask;
		sps_out_t        entry;
		int              i;
		int              j;
		int              n;
		width_table[item.channel] = item.pulse_width;
		for (i = 0; i < CHANNELS; i++) begin
			j = i;
			cur = 3'(i);
			while (j > 0 && width_table[order[j-1]] > width_table[cur]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = cur;
		end
		n = 0;
		i = 0;
		while (i < CHANNELS) begin
			mask = FULL_MASK;
			mask[order[i]] = 1'b0;
			// fold tied channels in, never past the final channel
			while (i < CHANNELS - 1 && width_table[order[i]] == width_table[order[i+1]]) begin
				i++;
				mask[order[i]] = 1'b0;
			end
			entry.event_time      = width_table[order[i]];
			entry.still_high_mask = mask;
			entry.last_entry      = (n == CHANNELS - 1);
			expected_entries.push_back(entry);
			n++;
			i++;
		end
		for (; n < CHANNELS; n++) begin
			entry = '0;
			entry.last_entry = (n == CHANNELS - 1);
			expected_entries.push_back(entry);
		end
	endfunction

	always @(posedge clk) begin : check_entries
		sps_out_t want;
		if (arst_n && strobe) begin
			if (expected_entries.size() == 0) begin
				$display("%0t: unexpected entry time=%0d mask=%02h last=%0b", $time,
					result.event_time, result.still_high_mask, result.last_entry);
				error_count++;
			end else begin
				want = expected_entries.pop_front();
				if (result.event_time !== want.event_time) begin
					$display("%0t: event_time expected %0d got %0d", $time,
						want.event_time, result.event_time);
					error_count++;
				end
				if (result.still_high_mask !== want.still_high_mask) begin
					$display("%0t: still_high_mask expected %02h got %02h", $time,
						want.still_high_mask, result.still_high_mask);
					error_count++;
				end
				if (result.last_entry !== want.last_entry) begin
					$display("%0t: last_entry expected %0b got %0b", $time,
						want.last_entry, result.last_entry);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item or entry accepted for %0d cycles", $time, idle_cycles);
			$display("servo_pulse_schedule_table_unit regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 19);
		if (roll < 8)
			return 0;
		if (roll < 17)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// Bias toward a few shared values so ties and merges show up often.
	function automatic logic [15:0] random_width();
		logic [15:0] pool [4] = '{16'd1000, 16'd1500, 16'd12000, 16'd40000};
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return pool[$urandom_range(0, 3)];
		if (roll == 4)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom);
	endfunction

	task automatic send_width(input logic [2:0] ch, input logic [15:0] w);
		int      gap;
		sps_in_t item;
		gap = pick_gap();
		item.channel     = ch;
		item.pulse_width = w;
		if (gap > 0) begin
			start <= 1'b0;
			cmd.channel     <= 3'($urandom);
			cmd.pulse_width <= 16'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= item;
		// hold until an edge with busy low takes the item
		do @(posedge clk); while (busy !== 1'b0);
		predict_schedule(item);
	endtask

	task automatic test_reset_widths();
		// every channel still at the reset width: one fully merged entry
		send_width(3'd0, RESET_WIDTH);
		send_width(3'd5, RESET_WIDTH);
	endtask

	task automatic test_width_extremes();
		send_width(3'd7, 16'hFFFF);
		send_width(3'd0, 16'h0000);
		send_width(3'd1, 16'hFFFE);
		send_width(3'd6, 16'h0001);
		send_width(3'd2, 16'h8000);
		send_width(3'd4, 16'h7FFF);
	endtask

	task automatic test_zero_width();
		send_width(3'd3, 16'h0000);
		send_width(3'd5, 16'h0000);
	endtask

	task automatic test_equal_widths();
		int ch;
		for (ch = 0; ch < CHANNELS; ch++)
			send_width(3'(ch), 16'd777);
		send_width(3'd7, 16'd776);
		send_width(3'd0, 16'd778);
	endtask

	task automatic test_random_writes();
		int k;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 25 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			send_width(3'($urandom), random_width());
		end
		gaps_on = 1'b1;
	endtask

	initial begin : run
		int i;
		for (i = 0; i < CHANNELS; i++)
			width_table[i] = RESET_WIDTH;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_widths();
		test_width_extremes();
		test_zero_width();
		test_equal_widths();
		test_random_writes();

		start <= 1'b0;
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (ITEM_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("servo_pulse_schedule_table_unit regression: pass");
		else
			$display("servo_pulse_schedule_table_unit regression: fail");
		$finish;
	end

endmodule
